[src/dfcd_pkg.sv]
`timescale 1ns / 1ps
package dfcd_pkg;

	localparam int PACK_LEN_DEF     = 8;
	localparam int MAX_WORD_LEN_DEF = 64;
	localparam int QUEUE_DEPTH      = 2;
	localparam int NUM_ENTRIES      = 256;
	localparam logic [7:0] LITERAL_MIN = 8'd32;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_DECODE = 2'd1;
	localparam logic [1:0] FUNC_END    = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] code;
		logic [2:0] position;
		logic [7:0] value;
		logic [3:0] length;
	} in_t;

	typedef struct packed {
		logic [63:0] text;
		logic [3:0]  count;
		logic        new_word;
		logic        block_end;
		logic        overflow;
		logic        last;
	} out_t;

endpackage

[src/dfcd_ram.sv]
`timescale 1ns / 1ps
module dfcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/dfcd_fifo.sv]
`timescale 1ns / 1ps
module dfcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = dfcd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = slot_q[rptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[src/dfcd_front.sv]
`timescale 1ns / 1ps
module dfcd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dfcd_pkg::in_t  item,
	output logic           full,
	input  logic           q_pop,
	output dfcd_pkg::in_t  q_data,
	output logic           q_empty
);

	logic known;

	// Items with an unknown function are taken and dropped here.
	always_comb begin
		unique case (item.func) inside
			dfcd_pkg::FUNC_LOAD, dfcd_pkg::FUNC_DECODE, dfcd_pkg::FUNC_END: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	dfcd_fifo #(
		.WIDTH($bits(dfcd_pkg::in_t)),
		.DEPTH(dfcd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && known),
		.wr_data (item),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

endmodule

[src/dfcd_back.sv]
`timescale 1ns / 1ps
module dfcd_back #(
	parameter int PACK_LEN     = dfcd_pkg::PACK_LEN_DEF,
	parameter int MAX_WORD_LEN = dfcd_pkg::MAX_WORD_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  dfcd_pkg::in_t  q_data,
	output logic           q_pop,
	input  logic           o_full,
	output logic           o_push,
	output dfcd_pkg::out_t o_data
);

	localparam int TAW = $clog2(dfcd_pkg::NUM_ENTRIES * PACK_LEN);
	localparam int WLW = $clog2(MAX_WORD_LEN + 1);
	localparam int WAW = $clog2(MAX_WORD_LEN);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LEN  = 7'b0000010,
		ST_TRD  = 7'b0000100,
		ST_TEX  = 7'b0001000,
		ST_CRD  = 7'b0010000,
		ST_CEX  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t          state_q, state_d;
	logic [7:0]      code_q, code_d;
	logic [3:0]      len_q, len_d, idx_q, idx_d;
	logic [4:0]      ccnt_q, ccnt_d, cidx_q, cidx_d;
	logic [WLW-1:0]  wl_q, wl_d, pfx;
	logic            abs_q, abs_d;
	logic [63:0]     ch_text_q, ch_text_d;
	logic [3:0]      ch_cnt_q, ch_cnt_d;
	logic            ch_new_q, ch_new_d, ch_over_q, ch_over_d, ch_open_q, ch_open_d;

	logic            tbl_we, len_we, wb_we;
	logic [TAW-1:0]  tbl_waddr, tbl_raddr;
	logic [7:0]      tbl_rd, wb_rd;
	logic [3:0]      len_wdata, len_rd, len_clamp;
	logic            put;
	logic [7:0]      put_b;
	logic            put_spill, more;
	state_t          next_st;

	assign tbl_waddr = TAW'(int'(q_data.code) * PACK_LEN + int'(q_data.position));
	assign tbl_raddr = TAW'(int'(code_q) * PACK_LEN + int'(idx_q));

	always_comb begin
		if (q_data.length == 4'd0) begin
			len_wdata = 4'd1;
		end else if (q_data.length > 4'(PACK_LEN)) begin
			len_wdata = 4'(PACK_LEN);
		end else begin
			len_wdata = q_data.length;
		end
		len_clamp = (len_rd > 4'(PACK_LEN)) ? 4'(PACK_LEN) : len_rd;
	end

	dfcd_ram #(.WIDTH(8), .DEPTH(dfcd_pkg::NUM_ENTRIES * PACK_LEN)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (q_data.value),
		.raddr (tbl_raddr),
		.rdata (tbl_rd)
	);

	// The length read is issued from the queue head so that it is ready in ST_LEN.
	dfcd_ram #(.WIDTH(4), .DEPTH(dfcd_pkg::NUM_ENTRIES)) u_lengths (
		.clk   (clk),
		.we    (len_we),
		.waddr (q_data.code),
		.wdata (len_wdata),
		.raddr (q_data.code),
		.rdata (len_rd)
	);

	dfcd_ram #(.WIDTH(8), .DEPTH(MAX_WORD_LEN)) u_word (
		.clk   (clk),
		.we    (wb_we),
		.waddr (wl_q[WAW-1:0]),
		.wdata (tbl_rd),
		.raddr (WAW'(cidx_q)),
		.rdata (wb_rd)
	);

	always_comb begin
		state_d   = state_q;
		code_d    = code_q;
		len_d     = len_q;
		idx_d     = idx_q;
		ccnt_d    = ccnt_q;
		cidx_d    = cidx_q;
		wl_d      = wl_q;
		abs_d     = abs_q;
		ch_text_d = ch_text_q;
		ch_cnt_d  = ch_cnt_q;
		ch_new_d  = ch_new_q;
		ch_over_d = ch_over_q;
		ch_open_d = ch_open_q;
		q_pop     = 1'b0;
		o_push    = 1'b0;
		tbl_we    = 1'b0;
		len_we    = 1'b0;
		wb_we     = 1'b0;
		put       = 1'b0;
		put_b     = tbl_rd;

		o_data.text      = ch_text_q;
		o_data.count     = ch_cnt_q;
		o_data.new_word  = ch_new_q;
		o_data.block_end = 1'b0;
		o_data.overflow  = ch_over_q;
		o_data.last      = 1'b0;

		put_spill = ch_open_q && (ch_cnt_q == 4'd8);
		more      = (idx_q + 4'd1) < len_q;
		next_st   = more ? ST_TRD : ST_FIN;
		pfx       = (WLW'(tbl_rd[4:0]) > wl_q) ? wl_q : WLW'(tbl_rd[4:0]);

		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					unique case (q_data.func)
						dfcd_pkg::FUNC_LOAD: begin
							q_pop  = 1'b1;
							len_we = 1'b1;
							tbl_we = ({1'b0, q_data.position} < 4'(PACK_LEN));
						end
						dfcd_pkg::FUNC_DECODE: begin
							q_pop     = 1'b1;
							code_d    = q_data.code;
							ch_open_d = 1'b0;
							state_d   = ST_LEN;
						end
						dfcd_pkg::FUNC_END: begin
							if (!o_full) begin
								q_pop            = 1'b1;
								o_push           = 1'b1;
								o_data.text      = '0;
								o_data.count     = '0;
								o_data.new_word  = 1'b0;
								o_data.overflow  = 1'b0;
								o_data.block_end = 1'b1;
								o_data.last      = 1'b1;
								wl_d             = '0;
								abs_d            = 1'b1;
							end
						end
						default: q_pop = 1'b1;
					endcase
				end
			end
			ST_LEN: begin
				len_d   = len_clamp;
				idx_d   = '0;
				state_d = (len_clamp == 4'd0) ? ST_FIN : ST_TRD;
			end
			ST_TRD: state_d = ST_TEX;
			ST_TEX: begin
				if (tbl_rd >= dfcd_pkg::LITERAL_MIN) begin
					if (wl_q < WLW'(MAX_WORD_LEN)) begin
						if (!put_spill || !o_full) begin
							abs_d   = 1'b0;
							wb_we   = 1'b1;
							wl_d    = wl_q + WLW'(1);
							put     = 1'b1;
							idx_d   = idx_q + 4'd1;
							state_d = next_st;
						end
					end else begin
						// Word is full: the literal is dropped and only flagged.
						abs_d = 1'b0;
						if (!ch_open_q) begin
							ch_open_d = 1'b1;
							ch_text_d = '0;
							ch_cnt_d  = '0;
							ch_new_d  = 1'b0;
						end
						ch_over_d = 1'b1;
						idx_d     = idx_q + 4'd1;
						state_d   = next_st;
					end
				end else if (!ch_open_q || !o_full) begin
					o_push    = ch_open_q;
					ch_open_d = 1'b1;
					ch_text_d = '0;
					ch_cnt_d  = '0;
					ch_new_d  = !abs_q;
					ch_over_d = 1'b0;
					wl_d      = pfx;
					abs_d     = 1'b0;
					idx_d     = idx_q + 4'd1;
					ccnt_d    = pfx[4:0];
					cidx_d    = '0;
					state_d   = (pfx == '0) ? next_st : ST_CRD;
				end
			end
			ST_CRD: state_d = ST_CEX;
			ST_CEX: begin
				put_b = wb_rd;
				if (!put_spill || !o_full) begin
					put    = 1'b1;
					cidx_d = cidx_q + 5'd1;
					if ((cidx_q + 5'd1) == ccnt_q) begin
						state_d = (idx_q < len_q) ? ST_TRD : ST_FIN;
					end else begin
						state_d = ST_CRD;
					end
				end
			end
			ST_FIN: begin
				if (!ch_open_q) begin
					state_d = ST_IDLE;
				end else if (!o_full) begin
					o_push      = 1'b1;
					o_data.last = 1'b1;
					ch_open_d   = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// Append one byte to the open result, opening one if none is open and spilling a full one first.
		if (put) begin
			if (put_spill || !ch_open_q) begin
				o_push    = put_spill;
				ch_open_d = 1'b1;
				ch_text_d = {56'd0, put_b};
				ch_cnt_d  = 4'd1;
				ch_new_d  = 1'b0;
				ch_over_d = 1'b0;
			end else begin
				ch_text_d[ch_cnt_q[2:0]*8 +: 8] = put_b;
				ch_cnt_d = ch_cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wl_q      <= '0;
			abs_q     <= 1'b1;
			ch_open_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			wl_q      <= wl_d;
			abs_q     <= abs_d;
			ch_open_q <= ch_open_d;
		end
	end

	always_ff @(posedge clk) begin
		code_q    <= code_d;
		len_q     <= len_d;
		idx_q     <= idx_d;
		ccnt_q    <= ccnt_d;
		cidx_q    <= cidx_d;
		ch_text_q <= ch_text_d;
		ch_cnt_q  <= ch_cnt_d;
		ch_new_q  <= ch_new_d;
		ch_over_q <= ch_over_d;
	end

endmodule

[src/dictionary_front_coding_decoder_core.sv]
`timescale 1ns / 1ps
// Front-coded word list decoder. Items enter through a short queue; the back end takes a
// table load or a block end straight from idle, while a decode reads the entry's length,
// then reads each byte of the entry's string from the string table and each byte copied
// as a word prefix from the word buffer, both registered reads, and takes no new item
// until it is done. Results leave through a two-entry queue.
module dictionary_front_coding_decoder_core #(
	parameter int PACK_LEN     = dfcd_pkg::PACK_LEN_DEF,
	parameter int MAX_WORD_LEN = dfcd_pkg::MAX_WORD_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  dfcd_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output dfcd_pkg::out_t result
);

	dfcd_pkg::in_t  q_data;
	dfcd_pkg::out_t o_data;
	logic           q_empty, q_pop, o_full, o_push;

	dfcd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.q_pop   (q_pop),
		.q_data  (q_data),
		.q_empty (q_empty)
	);

	dfcd_back #(
		.PACK_LEN     (PACK_LEN),
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.o_full  (o_full),
		.o_push  (o_push),
		.o_data  (o_data)
	);

	dfcd_fifo #(
		.WIDTH($bits(dfcd_pkg::out_t)),
		.DEPTH(dfcd_pkg::QUEUE_DEPTH)
	) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (o_push),
		.wr_data (o_data),
		.full    (o_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
